// File: rtl/lzss_stream_decompressor_core_assert.svh
// Assertion macros shared by the LZSS decompressor RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef LZSS_STREAM_DECOMPRESSOR_CORE_ASSERT_SVH
`define LZSS_STREAM_DECOMPRESSOR_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Property must hold at every clock edge outside reset.
`define LZSSD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("lzssd assertion failed");
// Condition must never be true outside reset.
`define LZSSD_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("lzssd forbidden condition seen");
`else
`define LZSSD_ASSERT(lbl, clk, rst_n, prop)
`define LZSSD_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

// File: rtl/lzssd_pkg.sv
// Shared types and constants of the LZSS stream decompressor.
// No dependencies; used by front, command queue, back and top level.
package lzssd_pkg;

  localparam int unsigned CountW   = 18;
  localparam int unsigned WinAw    = 12;  // 4096-byte history window
  localparam int unsigned LenW     = 5;   // match length up to 18
  localparam int unsigned MinMatch = 3;
  localparam int unsigned CmdDepth = 4;
  localparam logic [CountW-1:0] LimitReset = 18'd196608;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_OK   = 2'd1,
    KIND_ERR  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    CMD_LIT,
    CMD_MATCH,
    CMD_END,
    CMD_ERR
  } cmd_op_e;

  typedef enum logic [1:0] {
    PH_FLAG,
    PH_TOK,
    PH_HI
  } phase_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_READ,
    B_COPY,
    B_STATUS
  } back_state_e;

  // Command from the token parser to the copy engine
  typedef struct packed {
    cmd_op_e    op;
    logic       term;      // stream ends after this token
    logic [7:0] data;      // literal byte
    logic [11:0] off_m1;   // match offset minus one
    logic [3:0] len_code;  // match length minus MinMatch
  } cmd_t;

endpackage

// File: rtl/lzssd_front.sv
// Token parser: flag bits, literal and match decode, limit and range checks.
// Depends on lzssd_pkg; feeds commands into lzssd_cmd_fifo.
module lzssd_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [lzssd_pkg::CountW-1:0] cfg_wdata_i,
  input  logic                        accept_i,
  input  logic [7:0]                  in_byte_i,
  input  logic                        in_last_i,
  output logic                        cmd_valid_o,
  output lzssd_pkg::cmd_t             cmd_o
);

  logic [lzssd_pkg::CountW-1:0] limit_q;
  logic [7:0]                   flag_q, flag_d;
  logic [3:0]                   pos_q, pos_d;
  logic [7:0]                   lo_q, lo_d;
  lzssd_pkg::phase_e            phase_q, phase_d;
  logic [lzssd_pkg::CountW-1:0] cnt_q, cnt_d;
  logic                         err_q, err_d;

  logic [12:0]                  offset;
  logic [lzssd_pkg::LenW-1:0]   len;
  logic [lzssd_pkg::CountW:0]   end_sum;
  logic                         tok_lit, tok_match, fail;

  // Match geometry from the low byte and the current high byte
  assign offset  = {1'b0, in_byte_i[7:4], lo_q} + 13'd1;
  assign len     = {1'b0, in_byte_i[3:0]} + lzssd_pkg::LenW'(lzssd_pkg::MinMatch);
  assign end_sum = {1'b0, cnt_q} + (lzssd_pkg::CountW+1)'(len);

  // Limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= lzssd_pkg::LimitReset;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  // Token state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q  <= '0;
      pos_q   <= 4'd8;
      lo_q    <= '0;
      phase_q <= lzssd_pkg::PH_FLAG;
      cnt_q   <= '0;
      err_q   <= 1'b0;
    end else begin
      flag_q  <= flag_d;
      pos_q   <= pos_d;
      lo_q    <= lo_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      err_q   <= err_d;
    end
  end

  // Classify the accepted byte and build the command
  always_comb begin
    flag_d    = flag_q;
    pos_d     = pos_q;
    lo_d      = lo_q;
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    err_d     = err_q;
    tok_lit   = 1'b0;
    tok_match = 1'b0;
    fail      = 1'b0;
    cmd_valid_o     = 1'b0;
    cmd_o.op        = lzssd_pkg::CMD_END;
    cmd_o.term      = in_last_i;
    cmd_o.data      = in_byte_i;
    cmd_o.off_m1    = {in_byte_i[7:4], lo_q};
    cmd_o.len_code  = in_byte_i[3:0];

    if (accept_i) begin
      if (err_q) begin
        // discard until end of stream
        if (in_last_i) begin
          flag_d  = '0;
          pos_d   = 4'd8;
          lo_d    = '0;
          phase_d = lzssd_pkg::PH_FLAG;
          cnt_d   = '0;
          err_d   = 1'b0;
        end
      end else begin
        priority if (phase_q == lzssd_pkg::PH_FLAG || pos_q >= 4'd8) begin
          flag_d  = in_byte_i;
          pos_d   = 4'd0;
          phase_d = lzssd_pkg::PH_TOK;
        end else if (phase_q == lzssd_pkg::PH_TOK) begin
          if (!flag_q[pos_q[2:0]]) begin
            if (cnt_q >= limit_q) begin
              fail = 1'b1;
            end else begin
              tok_lit = 1'b1;
              cnt_d   = cnt_q + 1'b1;
            end
          end else begin
            lo_d    = in_byte_i;
            phase_d = lzssd_pkg::PH_HI;
          end
        end else begin
          if (cnt_q < lzssd_pkg::CountW'(offset) || end_sum > {1'b0, limit_q}) begin
            fail = 1'b1;
          end else begin
            tok_match = 1'b1;
            cnt_d     = end_sum[lzssd_pkg::CountW-1:0];
          end
        end

        // next flag bit after a finished token
        if (tok_lit || tok_match) begin
          pos_d   = pos_q + 4'd1;
          phase_d = (pos_q + 4'd1 >= 4'd8) ? lzssd_pkg::PH_FLAG : lzssd_pkg::PH_TOK;
          if (pos_q + 4'd1 >= 4'd8) begin
            pos_d = 4'd8;
          end
        end

        if (fail) begin
          cmd_valid_o = 1'b1;
          cmd_o.op    = lzssd_pkg::CMD_ERR;
          flag_d      = '0;
          pos_d       = 4'd8;
          lo_d        = '0;
          phase_d     = lzssd_pkg::PH_FLAG;
          cnt_d       = '0;
          err_d       = !in_last_i;
        end else begin
          cmd_valid_o = tok_lit || tok_match || in_last_i;
          if (tok_lit) begin
            cmd_o.op = lzssd_pkg::CMD_LIT;
          end else if (tok_match) begin
            cmd_o.op = lzssd_pkg::CMD_MATCH;
          end
          if (in_last_i) begin
            flag_d  = '0;
            pos_d   = 4'd8;
            lo_d    = '0;
            phase_d = lzssd_pkg::PH_FLAG;
            cnt_d   = '0;
          end
        end
      end
    end
  end

endmodule

// File: rtl/lzssd_cmd_fifo.sv
// Short command queue between the token parser and the copy engine.
// Depends on lzssd_pkg for the command type and depth.
`include "lzss_stream_decompressor_core_assert.svh"

module lzssd_cmd_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  lzssd_pkg::cmd_t push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output lzssd_pkg::cmd_t pop_data_o
);

  localparam int unsigned PtrW = $clog2(lzssd_pkg::CmdDepth);
  localparam int unsigned CntW = $clog2(lzssd_pkg::CmdDepth + 1);

  lzssd_pkg::cmd_t slots_q [lzssd_pkg::CmdDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] fill_q;
  logic            do_push, do_pop;

  assign full_o     = (fill_q == CntW'(lzssd_pkg::CmdDepth));
  assign empty_o    = (fill_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = slots_q[rd_ptr_q];

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (do_push && !do_pop) begin
        fill_q <= fill_q + 1'b1;
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

  // Slot storage
  always_ff @(posedge clk_i) begin
    if (do_push) slots_q[wr_ptr_q] <= push_data_i;
  end

  `LZSSD_ASSERT_NEVER(a_fill_range, clk_i, rst_ni, fill_q > CntW'(lzssd_pkg::CmdDepth))
  `LZSSD_ASSERT(a_fill_step, clk_i, rst_ni,
                (do_push && !do_pop) |=> fill_q == $past(fill_q) + 1'b1)

endmodule

// File: rtl/lzssd_back.sv
// Copy engine: history memory, match copy, output register with status results.
// Depends on lzssd_pkg; takes commands from lzssd_cmd_fifo.
`include "lzss_stream_decompressor_core_assert.svh"

module lzssd_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cmd_valid_i,
  input  lzssd_pkg::cmd_t              cmd_i,
  output logic                         cmd_pop_o,
  input  logic                         pop,
  output logic                         empty,
  output logic [7:0]                   out_byte_o,
  output logic [1:0]                   out_kind_o,
  output logic [lzssd_pkg::CountW-1:0] out_count_o,
  output logic                         out_last_o
);

  localparam int unsigned Aw = lzssd_pkg::WinAw;
  localparam int unsigned Lw = lzssd_pkg::LenW;
  localparam int unsigned Cw = lzssd_pkg::CountW;

  logic [7:0] hist_mem [2**Aw];

  lzssd_pkg::back_state_e state_q, state_d;
  logic [Cw-1:0]          cnt_q, cnt_d;
  logic [Aw-1:0]          src_q, src_d;
  logic [Lw-1:0]          rem_q, rem_d;
  logic                   term_q, term_d;
  lzssd_pkg::kind_e       stat_kind_q, stat_kind_d;
  logic [7:0]             byte_q;

  logic                   out_valid_q;
  logic [7:0]             obyte_q, obyte_d;
  lzssd_pkg::kind_e       okind_q, okind_d;
  logic [Cw-1:0]          ocount_q, ocount_d;
  logic                   olast_q, olast_d;

  logic slot_free, out_load, mem_we, rd_en, lit_load;

  assign slot_free   = !out_valid_q || pop;
  assign empty       = !out_valid_q;
  assign out_byte_o  = obyte_q;
  assign out_kind_o  = okind_q;
  assign out_count_o = ocount_q;
  assign out_last_o  = olast_q;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lzssd_pkg::B_IDLE;
      cnt_q       <= '0;
      src_q       <= '0;
      rem_q       <= '0;
      term_q      <= 1'b0;
      stat_kind_q <= lzssd_pkg::KIND_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      src_q       <= src_d;
      rem_q       <= rem_d;
      term_q      <= term_d;
      stat_kind_q <= stat_kind_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      obyte_q  <= obyte_d;
      okind_q  <= okind_d;
      ocount_q <= ocount_d;
      olast_q  <= olast_d;
    end
  end

  // History memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) hist_mem[cnt_q[Aw-1:0]] <= byte_q;
    if (rd_en) begin
      byte_q <= hist_mem[src_q];
    end else if (lit_load) begin
      byte_q <= cmd_i.data;
    end
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    src_d       = src_q;
    rem_d       = rem_q;
    term_d      = term_q;
    stat_kind_d = stat_kind_q;
    cmd_pop_o   = 1'b0;
    out_load    = 1'b0;
    mem_we      = 1'b0;
    rd_en       = 1'b0;
    lit_load    = 1'b0;
    obyte_d     = byte_q;
    okind_d     = lzssd_pkg::KIND_DATA;
    ocount_d    = cnt_q + 1'b1;
    olast_d     = 1'b0;

    unique case (state_q)
      lzssd_pkg::B_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          term_d    = cmd_i.term;
          unique case (cmd_i.op)
            lzssd_pkg::CMD_LIT: begin
              lit_load = 1'b1;
              rem_d    = Lw'(1);
              state_d  = lzssd_pkg::B_COPY;
            end
            lzssd_pkg::CMD_MATCH: begin
              src_d   = cnt_q[Aw-1:0] - cmd_i.off_m1 - Aw'(1);
              rem_d   = {1'b0, cmd_i.len_code} + Lw'(lzssd_pkg::MinMatch);
              state_d = lzssd_pkg::B_READ;
            end
            lzssd_pkg::CMD_END: begin
              stat_kind_d = lzssd_pkg::KIND_OK;
              state_d     = lzssd_pkg::B_STATUS;
            end
            default: begin
              stat_kind_d = lzssd_pkg::KIND_ERR;
              state_d     = lzssd_pkg::B_STATUS;
            end
          endcase
        end
      end
      lzssd_pkg::B_READ: begin
        rd_en   = 1'b1;
        state_d = lzssd_pkg::B_COPY;
      end
      lzssd_pkg::B_COPY: begin
        if (slot_free) begin
          out_load = 1'b1;
          olast_d  = (rem_q == Lw'(1)) && !term_q;
          mem_we   = 1'b1;
          cnt_d    = cnt_q + 1'b1;
          src_d    = src_q + 1'b1;
          rem_d    = rem_q - 1'b1;
          if (rem_q == Lw'(1)) begin
            if (term_q) begin
              stat_kind_d = lzssd_pkg::KIND_OK;
              state_d     = lzssd_pkg::B_STATUS;
            end else begin
              state_d = lzssd_pkg::B_IDLE;
            end
          end else begin
            state_d = lzssd_pkg::B_READ;
          end
        end
      end
      default: begin
        // status result closes the stream or reports an error
        if (slot_free) begin
          out_load = 1'b1;
          obyte_d  = '0;
          okind_d  = stat_kind_q;
          ocount_d = cnt_q;
          olast_d  = 1'b1;
          cnt_d    = '0;
          state_d  = lzssd_pkg::B_IDLE;
        end
      end
    endcase
  end

  `LZSSD_ASSERT_NEVER(a_rem_nonzero, clk_i, rst_ni,
                      (state_q == lzssd_pkg::B_READ || state_q == lzssd_pkg::B_COPY)
                      && rem_q == '0)
  `LZSSD_ASSERT_NEVER(a_no_overwrite, clk_i, rst_ni, out_load && out_valid_q && !pop)
  `LZSSD_ASSERT(a_status_clears, clk_i, rst_ni,
                (state_q == lzssd_pkg::B_STATUS && out_load) |=> cnt_q == '0)

endmodule

// File: rtl/lzss_stream_decompressor_core.sv
// LZSS stream decompressor, 4 KiB history window: byte in, decoded bytes out.
// Each compressed byte is taken by the token parser whenever the four-entry
// command queue has room; flag bytes and the first byte of a match cause no
// output. The copy engine then loads a literal into its byte register and
// emits it from B_COPY; a match costs a history read in B_READ and a write and
// emit in B_COPY per copied byte, and a status result is emitted from
// B_STATUS. Each emit waits for a free output register; the command queue lets
// the parser run ahead while results wait.
// Depends on lzssd_pkg, lzssd_front, lzssd_cmd_fifo and lzssd_back.
module lzss_stream_decompressor_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [lzssd_pkg::CountW-1:0] cfg_wdata_i,
  input  logic                         push,
  output logic                         full,
  input  logic [7:0]                   in_byte_i,
  input  logic                         in_last_i,
  output logic                         empty,
  input  logic                         pop,
  output logic [7:0]                   out_byte_o,
  output logic [1:0]                   out_kind_o,
  output logic [lzssd_pkg::CountW-1:0] out_count_o,
  output logic                         out_last_o
);

  logic            accept;
  logic            f_cmd_valid;
  lzssd_pkg::cmd_t f_cmd;
  logic            q_empty, q_pop;
  lzssd_pkg::cmd_t q_cmd;

  assign accept = push && !full;

  lzssd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .in_byte_i   (in_byte_i),
    .in_last_i   (in_last_i),
    .cmd_valid_o (f_cmd_valid),
    .cmd_o       (f_cmd)
  );

  lzssd_cmd_fifo u_cmd_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (f_cmd_valid),
    .push_data_i (f_cmd),
    .full_o      (full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .pop_data_o  (q_cmd)
  );

  lzssd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!q_empty),
    .cmd_i       (q_cmd),
    .cmd_pop_o   (q_pop),
    .pop         (pop),
    .empty       (empty),
    .out_byte_o  (out_byte_o),
    .out_kind_o  (out_kind_o),
    .out_count_o (out_count_o),
    .out_last_o  (out_last_o)
  );

endmodule

// File: tb/sv/lzss_stream_decompressor_core_checker.sv
// Checker for the LZSS stream decompressor: decodes the accepted compressed
// bytes on its own and compares every result transaction in order.
// Depends on lzssd_pkg.
module lzss_stream_decompressor_core_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [lzssd_pkg::CountW-1:0] cfg_wdata_i,
  input  logic                         push,
  input  logic                         full,
  input  logic [7:0]                   in_byte_i,
  input  logic                         in_last_i,
  input  logic                         empty,
  input  logic                         pop,
  input  logic [7:0]                   out_byte_i,
  input  logic [1:0]                   out_kind_i,
  input  logic [lzssd_pkg::CountW-1:0] out_count_i,
  input  logic                         out_last_i,
  output int                           pending_o,
  output int                           fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WinSize    = 1 << lzssd_pkg::WinAw;
  localparam int MaxPerByte = 19;  // 18 copied bytes plus a status

  typedef struct {
    logic [7:0]                   data;
    lzssd_pkg::kind_e             kind;
    logic [lzssd_pkg::CountW-1:0] count;
    logic                         last;
  } decoded_t;

  // Decoder state, mirrors the block's token parser and window
  logic [7:0]                   window_mem [WinSize];
  logic [7:0]                   flag_bits;
  logic [3:0]                   bit_pos;
  logic [7:0]                   match_lo;
  lzssd_pkg::phase_e            phase;
  logic [lzssd_pkg::CountW-1:0] produced;
  logic                         in_error;
  logic [lzssd_pkg::CountW-1:0] out_limit;

  // Results of one compressed byte, then the queue of results still due
  decoded_t step_res [MaxPerByte];
  int       step_n;
  decoded_t decoded_q [$];

  function automatic void clear_stream();
    flag_bits = 8'h00;
    bit_pos   = 4'd8;
    match_lo  = 8'h00;
    phase     = lzssd_pkg::PH_FLAG;
    produced  = '0;
    in_error  = 1'b0;
  endfunction

  function automatic void add_result(input logic [7:0] data, input lzssd_pkg::kind_e kind);
    step_res[step_n] = '{data: data, kind: kind, count: produced, last: 1'b0};
    step_n++;
  endfunction

  function automatic void emit_byte(input logic [7:0] data);
    window_mem[produced[lzssd_pkg::WinAw-1:0]] = data;
    produced = produced + 1'b1;
    add_result(data, lzssd_pkg::KIND_DATA);
  endfunction

  // Move to the next flag bit; a fresh flag byte follows the eighth token
  function automatic void next_token();
    bit_pos++;
    if (bit_pos >= 4'd8) begin
      bit_pos = 4'd8;
      phase   = lzssd_pkg::PH_FLAG;
    end else begin
      phase = lzssd_pkg::PH_TOK;
    end
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input logic last);
    int unsigned offset;
    int unsigned length;
    int unsigned i;
    logic        failed;
    step_n = 0;
    failed = 1'b0;
    // after an error everything up to the marked byte is dropped
    if (in_error) begin
      if (last) clear_stream();
      return;
    end
    if (phase == lzssd_pkg::PH_FLAG || bit_pos >= 4'd8) begin
      flag_bits = b;
      bit_pos   = 4'd0;
      phase     = lzssd_pkg::PH_TOK;
    end else if (phase == lzssd_pkg::PH_TOK) begin
      if (!flag_bits[bit_pos[2:0]]) begin
        if (produced >= out_limit) begin
          failed = 1'b1;
        end else begin
          emit_byte(b);
          next_token();
        end
      end else begin
        match_lo = b;
        phase    = lzssd_pkg::PH_HI;
      end
    end else begin
      offset = {b[7:4], match_lo} + 1;
      length = b[3:0] + lzssd_pkg::MinMatch;
      if (produced < offset || produced + length > out_limit) begin
        failed = 1'b1;
      end else begin
        // byte by byte, so an overlapping copy repeats what it just wrote
        for (i = 0; i < length; i++) begin
          emit_byte(window_mem[lzssd_pkg::WinAw'(produced - offset)]);
        end
        next_token();
      end
    end

    if (failed) begin
      add_result(8'h00, lzssd_pkg::KIND_ERR);
      if (last) begin
        clear_stream();
      end else begin
        flag_bits = 8'h00;
        bit_pos   = 4'd8;
        match_lo  = 8'h00;
        phase     = lzssd_pkg::PH_FLAG;
        in_error  = 1'b1;
      end
    end else if (last) begin
      add_result(8'h00, lzssd_pkg::KIND_OK);
      clear_stream();
    end
    if (step_n > 0) step_res[step_n-1].last = 1'b1;
    for (i = 0; i < step_n; i++) begin
      decoded_q.push_back(step_res[i]);
    end
  endfunction

  // Compare result transactions first, then apply config and input ones
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    decoded_t want;
    if (!rst_ni) begin
      clear_stream();
      out_limit = lzssd_pkg::LimitReset;
      foreach (window_mem[i]) window_mem[i] = 8'h00;
      decoded_q.delete();
      fail_count_o = 0;
    end else begin
      if (pop && !empty) begin
        if (decoded_q.size() == 0) begin
          $error("result with no expectation: byte %0d kind %0d count %0d",
                 out_byte_i, out_kind_i, out_count_i);
          fail_count_o++;
        end else begin
          want = decoded_q.pop_front();
          if (out_byte_i !== want.data) begin
            $error("out_byte: expected %0d, actual %0d", want.data, out_byte_i);
            fail_count_o++;
          end
          if (out_kind_i !== want.kind) begin
            $error("out_kind: expected %0d, actual %0d", want.kind, out_kind_i);
            fail_count_o++;
          end
          if (out_count_i !== want.count) begin
            $error("out_count: expected %0d, actual %0d", want.count, out_count_i);
            fail_count_o++;
          end
          if (out_last_i !== want.last) begin
            $error("out_last: expected %0d, actual %0d", want.last, out_last_i);
            fail_count_o++;
          end
        end
      end
      if (cfg_we_i) out_limit = cfg_wdata_i;
      if (push && !full) decode_byte(in_byte_i, in_last_i);
    end
    pending_o = decoded_q.size();
  end

endmodule

// File: tb/sv/lzss_stream_decompressor_core_test.sv
// Top of the LZSS decompressor testbench: clock, reset, directed and random
// compressed streams, output limit changes, idle and stall phases, verdict.
// Depends on lzssd_pkg, the block and lzss_stream_decompressor_core_checker.
module lzss_stream_decompressor_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DrainWait   = 200;  // covers a full command queue of long copies
  localparam int RandomItems = 410;
  localparam int Phases      = 8;

  logic                         clk_i       = 1'b0;
  logic                         rst_ni      = 1'b0;
  logic                         cfg_we_i    = 1'b0;
  logic [lzssd_pkg::CountW-1:0] cfg_wdata_i = '0;
  logic                         push        = 1'b0;
  logic                         full;
  logic [7:0]                   in_byte_i   = 8'h00;
  logic                         in_last_i   = 1'b0;
  logic                         empty;
  logic                         pop         = 1'b0;
  logic [7:0]                   out_byte_o;
  logic [1:0]                   out_kind_o;
  logic [lzssd_pkg::CountW-1:0] out_count_o;
  logic                         out_last_o;

  int pending;
  int fail_count;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int sent          = 0;

  logic [7:0] stream_q [$];  // compressed bytes of the next stream

  lzss_stream_decompressor_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push        (push),
    .full        (full),
    .in_byte_i   (in_byte_i),
    .in_last_i   (in_last_i),
    .empty       (empty),
    .pop         (pop),
    .out_byte_o  (out_byte_o),
    .out_kind_o  (out_kind_o),
    .out_count_o (out_count_o),
    .out_last_o  (out_last_o)
  );

  lzss_stream_decompressor_core_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .push         (push),
    .full         (full),
    .in_byte_i    (in_byte_i),
    .in_last_i    (in_last_i),
    .empty        (empty),
    .pop          (pop),
    .out_byte_i   (out_byte_o),
    .out_kind_i   (out_kind_o),
    .out_count_i  (out_count_o),
    .out_last_i   (out_last_o),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  always #1 clk_i = ~clk_i;

  // Receiver: random stalls at the current rate
  always @(negedge clk_i) begin
    pop <= ($urandom_range(0, 99) >= stall_pct);
  end

  // One input transaction, with random gaps before it
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push      <= 1'b1;
    in_byte_i <= b;
    in_last_i <= last;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    sent++;
    @(negedge clk_i);
  endtask

  // Send the queued stream, marking its final byte
  task automatic send_compressed();
    foreach (stream_q[i]) send_byte(stream_q[i], i == stream_q.size() - 1);
  endtask

  task automatic drain_results();
    push <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic settle();
    drain_results();
    repeat (DrainWait) @(negedge clk_i);
  endtask

  task automatic write_limit(input logic [lzssd_pkg::CountW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Well-formed stream: flag groups with literals and copies that stay inside
  // the output so far. Wild copies may reach before the start; a cut stream
  // ends at a random byte.
  task automatic make_stream(input int groups, input bit cut, input bit wild);
    int unsigned made;
    int unsigned off;
    int unsigned len;
    int unsigned reach;
    int          flag_at;
    int          keep;
    logic [7:0]  flag;
    stream_q.delete();
    made = 0;
    for (int g = 0; g < groups; g++) begin
      flag_at = stream_q.size();
      stream_q.push_back(8'h00);
      flag = 8'h00;
      for (int t = 0; t < 8; t++) begin
        if (made > 0 && $urandom_range(0, 1) == 1) begin
          flag[t] = 1'b1;
          reach = (made < 4096) ? made : 4096;
          if (wild && $urandom_range(0, 3) == 0) begin
            off = $urandom_range(1, 4096);
          end else if ($urandom_range(0, 1) == 1) begin
            // short offsets give overlapping copies
            off = $urandom_range(1, (reach < 18) ? reach : 18);
          end else begin
            off = $urandom_range(1, reach);
          end
          len = $urandom_range(0, 15);
          stream_q.push_back(8'(off - 1));
          stream_q.push_back({4'((off - 1) >> 8), 4'(len)});
          made += len + lzssd_pkg::MinMatch;
        end else begin
          stream_q.push_back(8'($urandom_range(0, 255)));
          made++;
        end
      end
      stream_q[flag_at] = flag;
    end
    if (cut) begin
      keep = $urandom_range(1, stream_q.size());
      while (stream_q.size() > keep) void'(stream_q.pop_back());
    end
  endtask

  // Random bytes, sometimes ending a stream
  task automatic send_noise();
    int n;
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++) begin
      send_byte(8'($urandom_range(0, 255)), i == n - 1 && $urandom_range(0, 3) == 0);
    end
  endtask

  // Run time limit
  initial begin
    #2_000_000;
    $display("lzss_stream_decompressor_core test failed");
    $finish;
  end

  initial begin
    logic [lzssd_pkg::CountW-1:0] limit_plan [Phases];
    int target;
    int halfway;
    int pick;
    bit paused;

    limit_plan = '{lzssd_pkg::LimitReset, 18'd1, 18'd48, 18'd0, 18'h3FFFF, 18'd300,
                   18'($urandom_range(2, 120)), lzssd_pkg::LimitReset};

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    write_limit(lzssd_pkg::LimitReset);

    // literals 00 and FF, overlapping copy of 18, short copy; ends mid-group
    stream_q = '{8'h0C, 8'h00, 8'hFF, 8'h00, 8'h0F, 8'h01, 8'h00, 8'hA5};
    send_compressed();
    // copy from before the stream start, then dropped bytes up to the marked one
    stream_q = '{8'h01, 8'hFF, 8'hF0, 8'h12, 8'h34, 8'h56};
    send_compressed();
    // stream ends on the first byte of a copy
    stream_q = '{8'h02, 8'h11, 8'h00};
    send_compressed();
    // stream ends on its flag byte
    stream_q = '{8'h00};
    send_compressed();
    // error on the marked byte itself
    stream_q = '{8'h01, 8'h10, 8'h00};
    send_compressed();
    settle();
    // output overflow on the second literal
    write_limit(18'd1);
    stream_q = '{8'h00, 8'h01, 8'h02, 8'h03};
    send_compressed();

    // Random phases, each with its own limit and idle pattern
    for (int ph = 0; ph < Phases; ph++) begin
      settle();
      write_limit(limit_plan[ph]);
      unique case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 50; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 50; end
        default: begin send_idle_pct = 7; stall_pct = 7; end
      endcase
      target  = sent + RandomItems / Phases;
      halfway = sent + RandomItems / (2 * Phases);
      paused  = 1'b0;
      while (sent < target) begin
        if (!paused && sent >= halfway) begin
          drain_results();
          paused = 1'b1;
        end
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          send_noise();
        end else begin
          make_stream(($urandom_range(0, 7) == 0) ? $urandom_range(4, 6) : $urandom_range(1, 3),
                      pick == 1, pick == 2);
          // shorten the closing stream so the phase keeps its share of items
          while (stream_q.size() > 1 && sent + stream_q.size() > target) begin
            void'(stream_q.pop_back());
          end
          send_compressed();
        end
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("lzss_stream_decompressor_core test passed");
    end else begin
      $display("lzss_stream_decompressor_core test failed");
    end
    $finish;
  end

endmodule
